[hdl/hfd_pkg.sv]
// ----------------------------------------------------------------------------
// hfd_pkg: shared types, constants and the CRC step for the frame decoder
// Holds the frame layout, status codes, inter-module words and the
// reflected CRC-16 byte update.
// ----------------------------------------------------------------------------
package hfd_pkg;

    // frame layout (byte positions, four bits hold 0..8)
    localparam int          POS_W        = 4;
    localparam logic [3:0]  FRAME_LEN    = 4'd8;   // also the idle position
    localparam logic [3:0]  POS_CODE     = 4'd0;
    localparam logic [3:0]  POS_HUM_HI   = 4'd2;
    localparam logic [3:0]  POS_HUM_LO   = 4'd3;
    localparam logic [3:0]  POS_TEMP_HI  = 4'd4;
    localparam logic [3:0]  POS_TEMP_LO  = 4'd5;
    localparam logic [3:0]  CRC_END      = 4'd6;   // first byte not in the CRC
    localparam logic [3:0]  POS_CRC_LO   = 4'd6;
    localparam logic [3:0]  POS_LAST     = 4'd7;

    // CRC and protocol constants
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [7:0]  FUNC_CODE    = 8'h03;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CODE = 2'd1,
        ST_BAD_CRC  = 2'd2
    } t_status;

    // one received word as held in the input register
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } t_in_word;

    // one decoded result
    typedef struct packed {
        t_status            status;
        logic signed [15:0] temperature_tenths;
        logic [15:0]        humidity_tenths;
    } t_result;

    // reflected CRC-16, one byte: eight shift/xor steps on 16 bits
    function automatic logic [15:0] crc_add_byte(input logic [15:0] crc_in,
                                                 input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[hdl/hfd_in_reg.sv]
// ----------------------------------------------------------------------------
// hfd_in_reg: input register
// Captures one received word; frees itself when the decode stage advances,
// so a new word can be taken in the same cycle.
// ----------------------------------------------------------------------------
module hfd_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  hfd_pkg::t_in_word i_word,
    output logic              o_ready,
    input  logic              i_advance,
    output logic              o_word_valid,
    output hfd_pkg::t_in_word o_word
);
    import hfd_pkg::*;

    logic     r_valid;
    t_in_word r_word;

    // room when empty or when the held word moves on this cycle
    assign o_ready = !r_valid || i_advance;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_word;
        end
    end

    assign o_word_valid = r_valid;
    assign o_word       = r_word;

endmodule

[hdl/hfd_frame.sv]
// ----------------------------------------------------------------------------
// hfd_frame: frame tracker and decoder
// Keeps the byte position, running CRC and captured fields of the current
// frame and forms the result when the last byte arrives.
// ----------------------------------------------------------------------------
module hfd_frame (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_word_valid,
    input  hfd_pkg::t_in_word i_word,
    input  logic              i_advance,
    output logic              o_done,
    output hfd_pkg::t_result  o_result
);
    import hfd_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic [15:0]      r_crc;
    logic             r_code_ok;
    logic [15:0]      r_hum;
    logic [15:0]      r_temp;
    logic [7:0]       r_crc_lo;

    logic [POS_W-1:0] n_pos;
    logic [15:0]      n_crc;
    logic [POS_W-1:0] cur_pos;
    logic [15:0]      cur_crc;
    logic             active;
    logic [15:0]      rx_crc;
    logic [15:0]      mag;
    logic [15:0]      temp_val;

    // a start word restarts at byte 0 with a fresh CRC
    assign cur_pos = i_word.frame_start ? POS_CODE : r_pos;
    assign cur_crc = i_word.frame_start ? CRC_INIT : r_crc;
    assign active  = (cur_pos < FRAME_LEN);

    // next position and CRC
    always_comb begin
        n_pos = cur_pos;
        n_crc = cur_crc;
        if (active) begin
            n_pos = (cur_pos == POS_LAST) ? FRAME_LEN : cur_pos + 1'b1;
            if (cur_pos < CRC_END) begin
                n_crc = crc_add_byte(cur_crc, i_word.rx_byte);
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= FRAME_LEN;
            r_crc     <= CRC_INIT;
            r_code_ok <= 1'b0;
        end else if (i_advance) begin
            r_pos <= n_pos;
            r_crc <= n_crc;
            if (active && cur_pos == POS_CODE) begin
                r_code_ok <= (i_word.rx_byte == FUNC_CODE);
            end
        end
    end

    // captured frame fields, always written before they are read
    always_ff @(posedge i_clk) begin
        if (i_advance && active) begin
            case (cur_pos)
                POS_HUM_HI:  r_hum[15:8]  <= i_word.rx_byte;
                POS_HUM_LO:  r_hum[7:0]   <= i_word.rx_byte;
                POS_TEMP_HI: r_temp[15:8] <= i_word.rx_byte;
                POS_TEMP_LO: r_temp[7:0]  <= i_word.rx_byte;
                POS_CRC_LO:  r_crc_lo     <= i_word.rx_byte;
                default: ;
            endcase
        end
    end

    // last byte of the frame produces the result
    assign o_done = i_word_valid && active && (cur_pos == POS_LAST);

    // sign and magnitude to two's complement; negative zero gives 0
    assign rx_crc   = {i_word.rx_byte, r_crc_lo};
    assign mag      = {1'b0, r_temp[14:0]};
    assign temp_val = r_temp[15] ? (16'd0 - mag) : mag;

    always_comb begin
        o_result.status             = ST_OK;
        o_result.temperature_tenths = '0;
        o_result.humidity_tenths    = '0;
        if (!r_code_ok) begin
            o_result.status = ST_BAD_CODE;
        end else if (rx_crc != cur_crc) begin
            o_result.status = ST_BAD_CRC;
        end else begin
            o_result.temperature_tenths = temp_val;
            o_result.humidity_tenths    = r_hum;
        end
    end

    // position never goes past idle
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= FRAME_LEN)
        else $error("byte position out of range");

    // the last byte leaves the tracker idle
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && o_done) |=> (r_pos == FRAME_LEN))
        else $error("tracker not idle after last byte");

    // error results carry zero values
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != ST_OK) |->
        (o_result.temperature_tenths == 16'sd0 && o_result.humidity_tenths == 16'd0))
        else $error("error result with non-zero values");

endmodule

[hdl/humidity_frame_decoder.sv]
// ----------------------------------------------------------------------------
// humidity_frame_decoder: sensor reply frame decoder
// Result path: byte 7 passes the input register, then the result
//          register, which drives o_valid.
// Throughput: one byte per cycle; stalls only while a result waits on i_ready.
// Reset: synchronous, active low; tracker idles until a start word.
// ----------------------------------------------------------------------------
module humidity_frame_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_frame_start,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic signed [15:0] o_temperature_tenths,
    output logic [15:0]        o_humidity_tenths
);
    import hfd_pkg::*;

    t_in_word in_word;
    t_in_word held_word;
    logic     held_valid;
    logic     done;
    logic     advance;
    logic     out_free;
    t_result  result;

    logic     r_out_valid;
    t_result  r_out;

    assign in_word.rx_byte     = i_rx_byte;
    assign in_word.frame_start = i_frame_start;

    hfd_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_word       (in_word),
        .o_ready      (o_ready),
        .i_advance    (advance),
        .o_word_valid (held_valid),
        .o_word       (held_word)
    );

    hfd_frame u_frame (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_word_valid (held_valid),
        .i_word       (held_word),
        .i_advance    (advance),
        .o_done       (done),
        .o_result     (result)
    );

    // held word moves on unless it makes a result with nowhere to put it
    assign out_free = !r_out_valid || i_ready;
    assign advance  = held_valid && (!done || out_free);

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && done) begin
            r_out <= result;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_status             = r_out.status;
    assign o_temperature_tenths = r_out.temperature_tenths;
    assign o_humidity_tenths    = r_out.humidity_tenths;

    // a finished frame shows up in the next cycle
    a_done_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && done) |=> o_valid)
        else $error("result lost");

    // a frame never completes into an occupied, stalled result register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && done) |-> out_free)
        else $error("result register overwritten");

    // an empty input register always takes a word
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !held_valid |-> o_ready)
        else $error("input register empty but not ready");

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for humidity_frame_decoder
// Feeds sensor reply frames a word at a time and predicts every decoded
// reading on the fly. A short directed table covers idle bytes, the value
// extremes, restarts, negative zero and the bad-code error. Random frames
// follow, mostly well formed, in three idling phases, the first with a long
// output hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import hfd_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PHASE_WORDS   = 340;
    localparam int DIRECTED_ROWS = 28;

    // where a directed row takes its byte from
    typedef enum logic [1:0] {
        SRC_RAW,
        SRC_CRC_LO,
        SRC_CRC_HI,
        SRC_CRC_LO_BAD
    } t_byte_src;

    typedef struct packed {
        t_byte_src  src;
        logic       start;
        logic [7:0] rx_byte;
        logic       typed;
        t_result    want;
    } t_stim_row;

    localparam t_result NO_WANT = '0;

    // directed words; readings typed in where they are obvious
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        // stray word straight after reset: dropped
        '{SRC_RAW,        1'b0, 8'hA5, 1'b0, NO_WANT},
        // good frame, all-ones payload: full humidity, most negative temperature
        '{SRC_RAW,        1'b1, 8'h03, 1'b0, NO_WANT},
        '{SRC_RAW,        1'b0, 8'h04, 1'b0, NO_WANT},
        '{SRC_RAW,        1'b0, 8'hFF, 1'b0, NO_WANT},
        '{SRC_RAW,        1'b0, 8'hFF, 1'b0, NO_WANT},
        '{SRC_RAW,        1'b0, 8'hFF, 1'b0, NO_WANT},
        '{SRC_RAW,        1'b0, 8'hFF, 1'b0, NO_WANT},
        '{SRC_CRC_LO,     1'b0, 8'h00, 1'b0, NO_WANT},
        '{SRC_CRC_HI,     1'b0, 8'h00, 1'b1, '{ST_OK, -16'sd32767, 16'hFFFF}},
        // partial frame with a bad code, cut short by a restart
        '{SRC_RAW,        1'b1, 8'hFF, 1'b0, NO_WANT},
        '{SRC_RAW,        1'b0, 8'h00, 1'b0, NO_WANT},
        // good frame, zero humidity, negative zero temperature
        '{SRC_RAW,        1'b1, 8'h03, 1'b0, NO_WANT},
        '{SRC_RAW,        1'b0, 8'h04, 1'b0, NO_WANT},
        '{SRC_RAW,        1'b0, 8'h00, 1'b0, NO_WANT},
        '{SRC_RAW,        1'b0, 8'h00, 1'b0, NO_WANT},
        '{SRC_RAW,        1'b0, 8'h80, 1'b0, NO_WANT},
        '{SRC_RAW,        1'b0, 8'h00, 1'b0, NO_WANT},
        '{SRC_CRC_LO,     1'b0, 8'h00, 1'b0, NO_WANT},
        '{SRC_CRC_HI,     1'b0, 8'h00, 1'b1, '{ST_OK, 16'sd0, 16'h0000}},
        // bad code and bad CRC together: code wins
        '{SRC_RAW,        1'b1, 8'h00, 1'b0, NO_WANT},
        '{SRC_RAW,        1'b0, 8'h04, 1'b0, NO_WANT},
        '{SRC_RAW,        1'b0, 8'h12, 1'b0, NO_WANT},
        '{SRC_RAW,        1'b0, 8'h34, 1'b0, NO_WANT},
        '{SRC_RAW,        1'b0, 8'h56, 1'b0, NO_WANT},
        '{SRC_RAW,        1'b0, 8'h78, 1'b0, NO_WANT},
        '{SRC_CRC_LO_BAD, 1'b0, 8'h00, 1'b0, NO_WANT},
        '{SRC_CRC_HI,     1'b0, 8'h00, 1'b1, '{ST_BAD_CODE, 16'sd0, 16'h0000}},
        // word after a complete frame: dropped
        '{SRC_RAW,        1'b0, 8'h5A, 1'b0, NO_WANT}
    };

    logic               i_clk;
    logic               i_rst_n       = 1'b0;
    logic               i_valid       = 1'b0;
    logic [7:0]         i_rx_byte     = 8'h00;
    logic               i_frame_start = 1'b0;
    logic               i_ready       = 1'b0;
    logic               o_ready;
    logic               o_valid;
    logic [1:0]         o_status;
    logic signed [15:0] o_temperature_tenths;
    logic [15:0]        o_humidity_tenths;

    // decoder model state
    logic [3:0]  frame_pos = FRAME_LEN;
    logic [15:0] crc_acc   = CRC_INIT;
    logic        code_good = 1'b0;
    logic [15:0] hum_word  = '0;
    logic [15:0] temp_word = '0;
    logic [7:0]  crc_lo    = '0;

    t_result pending_readings [$];
    int      errors      = 0;
    int      words_taken = 0;
    int      tx_idle_pct = 0;
    int      rx_idle_pct = 0;
    int      cycle_count = 0;
    int      hold_left   = 0;
    bit      hold_req    = 1'b0;

    humidity_frame_decoder i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_rx_byte            (i_rx_byte),
        .i_frame_start        (i_frame_start),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_status             (o_status),
        .o_temperature_tenths (o_temperature_tenths),
        .o_humidity_tenths    (o_humidity_tenths)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // reflected CRC-16, fed one data bit at a time, LSB first
    function automatic logic [15:0] crc16_update(input logic [15:0] acc,
                                                 input logic [7:0]  d);
        logic [15:0] r;
        r = acc;
        for (int i = 0; i < 8; i++) begin
            r = (r[0] ^ d[i]) ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    // advance the model by one accepted word; reading out after byte 7
    task automatic decode_reply_byte(input logic [7:0] b, input logic s,
                                     output bit consumed, output bit produced,
                                     output t_result res);
        logic [15:0] mag;
        consumed = 1'b0;
        produced = 1'b0;
        res      = '0;
        if (s) begin
            frame_pos = POS_CODE;
            crc_acc   = CRC_INIT;
        end
        if (frame_pos < FRAME_LEN) begin
            consumed = 1'b1;
            if (frame_pos < CRC_END)
                crc_acc = crc16_update(crc_acc, b);
            case (frame_pos)
                POS_CODE:    code_good       = (b == FUNC_CODE);
                POS_HUM_HI:  hum_word[15:8]  = b;
                POS_HUM_LO:  hum_word[7:0]   = b;
                POS_TEMP_HI: temp_word[15:8] = b;
                POS_TEMP_LO: temp_word[7:0]  = b;
                POS_CRC_LO:  crc_lo          = b;
                default: ;
            endcase
            if (frame_pos == POS_LAST) begin
                frame_pos = FRAME_LEN;
                produced  = 1'b1;
                if (!code_good) begin
                    res.status = ST_BAD_CODE;
                end else if ({b, crc_lo} != crc_acc) begin
                    res.status = ST_BAD_CRC;
                end else begin
                    // sign and magnitude to two's complement
                    mag = {1'b0, temp_word[14:0]};
                    res.status             = ST_OK;
                    res.temperature_tenths = temp_word[15] ? -mag : mag;
                    res.humidity_tenths    = hum_word;
                end
            end else begin
                frame_pos = frame_pos + 4'd1;
            end
        end
    endtask

    // offer one word, with a random gap first; valid stays up afterwards
    task automatic send_word(input logic [7:0] b, input logic s,
                             input bit typed, input t_result want);
        bit      consumed;
        bit      produced;
        t_result res;
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_valid       <= 1'b1;
        i_rx_byte     <= b;
        i_frame_start <= s;
        // DUT outputs only move in the NBA region, so this sees the pre-edge value
        do @(posedge i_clk); while (!o_ready);
        decode_reply_byte(b, s, consumed, produced, res);
        if (consumed)
            words_taken++;
        if (produced)
            pending_readings.push_back(typed ? want : res);
    endtask

    // drop valid and wait for every pending reading, then a short margin
    task automatic settle();
        i_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one random frame: mostly good, some broken, cut short or stray words
    task automatic send_random_frame();
        logic [7:0] body [6];
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] flip;
        int         kind;
        int         len;
        kind = $urandom_range(99);
        for (int k = 0; k < 6; k++)
            body[k] = 8'($urandom_range(255));
        body[0] = FUNC_CODE;
        // negative or positive zero now and then
        if ($urandom_range(7) == 0) begin
            body[4][6:0] = 7'd0;
            body[5]      = 8'h00;
        end
        if (kind < 12) begin
            body[0] = 8'($urandom_range(255));
            if (body[0] == FUNC_CODE)
                body[0] = body[0] ^ 8'h80;
        end else if (kind < 20) begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
                send_word(body[k], k == 0, 1'b0, NO_WANT);
            return;
        end else if (kind < 28) begin
            len = $urandom_range(1, 4);
            for (int k = 0; k < len; k++)
                send_word(8'($urandom_range(255)), $urandom_range(7) == 0, 1'b0, NO_WANT);
            return;
        end
        for (int k = 0; k < 6; k++)
            send_word(body[k], k == 0, 1'b0, NO_WANT);
        lo   = crc_acc[7:0];
        hi   = crc_acc[15:8];
        flip = 8'($urandom_range(1, 255));
        if (kind < 6 || (kind >= 28 && kind < 40)) begin
            if ($urandom_range(1) == 0)
                lo = lo ^ flip;
            else
                hi = hi ^ flip;
        end
        send_word(lo, 1'b0, 1'b0, NO_WANT);
        send_word(hi, 1'b0, 1'b0, NO_WANT);
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input bit with_hold);
        int first_word;
        bit hold_sent;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        first_word  = words_taken;
        hold_sent   = 1'b0;
        while (words_taken - first_word < PHASE_WORDS) begin
            // long output stall while words keep coming
            if (with_hold && !hold_sent && words_taken - first_word >= PHASE_WORDS / 2) begin
                hold_req  = 1'b1;
                hold_sent = 1'b1;
            end
            send_random_frame();
        end
        settle();
    endtask

    // reading checker and output stall generator
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_readings.size() == 0) begin
                $display("%0t: unexpected reading: status %0d temp %0d hum %0d", $time,
                         o_status, o_temperature_tenths, o_humidity_tenths);
                errors++;
            end else begin
                want = pending_readings.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d got %0d", $time,
                             want.status, o_status);
                    errors++;
                end
                if (o_temperature_tenths !== want.temperature_tenths) begin
                    $display("%0t: temperature expected %0d got %0d", $time,
                             want.temperature_tenths, o_temperature_tenths);
                    errors++;
                end
                if (o_humidity_tenths !== want.humidity_tenths) begin
                    $display("%0t: humidity expected %0d got %0d", $time,
                             want.humidity_tenths, o_humidity_tenths);
                    errors++;
                end
            end
        end
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // run-away guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // stimulus
    initial begin
        logic [7:0] b;
        t_stim_row  row;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 37;
        rx_idle_pct = 55;
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            row = DIRECTED[i];
            case (row.src)
                SRC_CRC_LO:     b = crc_acc[7:0];
                SRC_CRC_HI:     b = crc_acc[15:8];
                SRC_CRC_LO_BAD: b = crc_acc[7:0] ^ 8'h5A;
                default:        b = row.rx_byte;
            endcase
            send_word(b, row.start, row.typed, row.want);
        end
        settle();

        run_phase(37, 55, 1'b1);
        run_phase(55, 37, 1'b0);
        run_phase(0, 0, 1'b0);

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[files.f]
hdl/hfd_pkg.sv
hdl/hfd_in_reg.sv
hdl/hfd_frame.sv
hdl/humidity_frame_decoder.sv
test/testbench.sv
